// ----- design/kmp_pkg.sv -----
// shared types, codes and defaults for the kmp pattern matcher
package kmp_pkg;

  localparam int MAX_PATTERN_DEF   = 256;
  localparam int POSITION_BITS_DEF = 32;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SCAN    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } kmp_state_t;

endpackage

// ----- design/kmp_store.sv -----
// pattern byte and border value memories with registered reads
module kmp_store
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int IW = $clog2(MAX_PATTERN)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [7:0]    wr_pat,
  input  logic [IW-1:0] wr_brd,
  input  logic [IW-1:0] pat_raddr,
  input  logic [IW-1:0] brd_raddr,
  output logic [7:0]    pat_q,
  output logic [IW-1:0] brd_q
);

  logic [7:0]    pat_mem [MAX_PATTERN];
  logic [IW-1:0] brd_mem [MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_mem[wr_addr] <= wr_pat;
      brd_mem[wr_addr] <= wr_brd;
    end
    pat_q <= pat_mem[pat_raddr];
    brd_q <= brd_mem[brd_raddr];
  end

endmodule

// ----- design/kmp_pattern_matcher.sv -----
// kmp pattern matcher top level: request decode, failure-chain sequencer, result register
// clear, restart, pattern-full, empty-scan and first-byte append: result registered in the cycle after accept
// other appends and scans: walk the failure chain in S_WALK, comparing each step against the registered
//   pattern/border reads, then load the result
// next request taken once the sequencer is back in S_IDLE, unless a pending result is stalled
// synchronous active-low reset clears lengths, position, sequencer and result valid
module kmp_pattern_matcher
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  localparam int IW = $clog2(MAX_PATTERN),
  localparam int LW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic [7:0]               in_byte_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [LW-1:0]            out_border_length,
  output logic                     out_match_found,
  output logic [POSITION_BITS-1:0] out_match_start
);

  localparam int PB = POSITION_BITS;
  localparam int SW = (PB > LW) ? PB : LW;

  kmp_state_t    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] matched_r, matched_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [IW-1:0] last_brd_r, last_brd_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [1:0]    op_r;
  logic [7:0]    byte_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [LW-1:0] out_border_r;
  logic          out_found_r;
  logic [PB-1:0] out_start_r;

  logic          res_load;
  logic [1:0]    res_status;
  logic [LW-1:0] res_border;
  logic          res_found;
  logic [PB-1:0] res_start;

  logic          wr_en;
  logic [7:0]    wr_pat;
  logic [IW-1:0] wr_brd;
  logic [7:0]    pat_q;
  logic [IW-1:0] brd_q;

  logic          accept;
  logic          eq;
  logic [LW-1:0] kf;
  logic [LW-1:0] len_m1;
  logic [SW-1:0] start_w;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign eq     = (pat_q == byte_r);
  assign kf     = k_r + LW'(eq);
  assign len_m1 = len_r - LW'(1);
  assign start_w = SW'(pos_r) - SW'(len_m1);

  kmp_store #(.MAX_PATTERN(MAX_PATTERN)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (len_r[IW-1:0]),
    .wr_pat    (wr_pat),
    .wr_brd    (wr_brd),
    .pat_raddr (k_nxt[IW-1:0]),
    .brd_raddr (IW'(k_nxt - LW'(1))),
    .pat_q     (pat_q),
    .brd_q     (brd_q)
  );

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    matched_nxt  = matched_r;
    pos_nxt      = pos_r;
    last_brd_nxt = last_brd_r;
    k_nxt        = k_r;
    wr_en        = 1'b0;
    wr_pat       = byte_r;
    wr_brd       = kf[IW-1:0];
    res_load     = 1'b0;
    res_status   = ST_OK;
    res_border   = '0;
    res_found    = 1'b0;
    res_start    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_CLEAR: begin
              len_nxt     = '0;
              matched_nxt = '0;
              pos_nxt     = '0;
              res_load    = 1'b1;
            end
            OP_APPEND: begin
              if (len_r == LW'(MAX_PATTERN)) begin
                res_load   = 1'b1;
                res_status = ST_FULL;
              end else if (len_r == '0) begin
                // first byte has no border, store it at once
                wr_en        = 1'b1;
                wr_pat       = in_byte_value;
                wr_brd       = '0;
                len_nxt      = LW'(1);
                last_brd_nxt = '0;
                res_load     = 1'b1;
              end else begin
                k_nxt     = LW'(last_brd_r);
                state_nxt = S_WALK;
              end
            end
            OP_SCAN: begin
              if (len_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                k_nxt     = matched_r;
                state_nxt = S_WALK;
              end
            end
            OP_RESTART: begin
              matched_nxt = '0;
              pos_nxt     = '0;
              res_load    = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (k_r != '0 && !eq) begin
          // mismatch: follow the failure link, read data returns next cycle
          k_nxt = LW'(brd_q);
        end else begin
          state_nxt  = S_IDLE;
          res_load   = 1'b1;
          res_border = kf;
          if (op_r == OP_APPEND) begin
            wr_en        = 1'b1;
            len_nxt      = len_r + LW'(1);
            last_brd_nxt = kf[IW-1:0];
          end else begin
            pos_nxt = pos_r + PB'(1);
            if (kf == len_r) begin
              res_found   = 1'b1;
              res_start   = start_w[PB-1:0];
              matched_nxt = LW'(last_brd_r);
            end else begin
              matched_nxt = kf;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      matched_r   <= '0;
      pos_r       <= '0;
      last_brd_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      matched_r  <= matched_nxt;
      pos_r      <= pos_nxt;
      last_brd_r <= last_brd_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (accept) begin
      op_r   <= in_operation;
      byte_r <= in_byte_value;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_border_r <= res_border;
      out_found_r  <= res_found;
      out_start_r  <= res_start;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_border_length = out_border_r;
  assign out_match_found   = out_found_r;
  assign out_match_start   = out_start_r;

  // no result is pending while the chain walk is running
  a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> !out_valid_r)
    else $error("result pending during chain walk");

  // matched length stays a proper prefix of a nonempty pattern
  a_matched_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r != '0 |-> matched_r < len_r)
    else $error("matched length not below pattern length");

  // the walk only reads entries that were written
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> k_r < len_r)
    else $error("chain walk index beyond pattern");

  // pattern length moves by at most one per cycle unless cleared
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    len_r != $past(len_r) |-> len_r == '0 || len_r == $past(len_r) + LW'(1))
    else $error("pattern length jumped");

endmodule

// ----- dv/kmp_match_checker.sv -----
// kmp matcher checker: predicts each result from accepted requests and compares the results
module kmp_match_checker
  import kmp_pkg::*;
#(
  parameter int MAX_LEN = MAX_PATTERN_DEF,
  parameter int POS_W = POSITION_BITS_DEF,
  localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_byte_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_status,
  input  logic [LEN_W-1:0] out_border_length,
  input  logic             out_match_found,
  input  logic [POS_W-1:0] out_match_start,
  output int unsigned      error_count,
  output int unsigned      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] border;
    logic             found;
    logic [POS_W-1:0] start;
  } kmp_result_t;

  logic [7:0]       pat_bytes [MAX_LEN];
  int unsigned      borders [MAX_LEN];
  int unsigned      pat_len;
  int unsigned      match_len;
  logic [POS_W-1:0] text_pos;
  kmp_result_t      expected_q [$];

  // grow a matched length by one byte, falling back along the failure chain
  function automatic int unsigned extend_match(int unsigned k, logic [7:0] b);
    while (k > 0 && k < MAX_LEN && pat_bytes[k] != b) k = borders[k-1];
    if (k < MAX_LEN && pat_bytes[k] == b) k++;
    return k;
  endfunction

  function automatic kmp_result_t predict_result(logic [1:0] op, logic [7:0] b);
    kmp_result_t r;
    int unsigned k;
    r = '0;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        match_len = 0;
        text_pos = '0;
      end
      OP_APPEND: begin
        if (pat_len >= MAX_LEN) begin
          r.status = ST_FULL;
        end else begin
          k = (pat_len > 0) ? extend_match(borders[pat_len-1], b) : 0;
          pat_bytes[pat_len] = b;
          borders[pat_len] = k;
          pat_len++;
          r.border = LEN_W'(k);
        end
      end
      OP_SCAN: begin
        if (pat_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = extend_match(match_len, b);
          r.border = LEN_W'(k);
          if (k >= pat_len) begin
            r.found = 1'b1;
            r.start = text_pos - POS_W'(pat_len - 1);
            // keep going from the border so overlapping hits are seen
            k = borders[pat_len-1];
          end
          match_len = k;
          text_pos = text_pos + 1'b1;
        end
      end
      default: begin
        match_len = 0;
        text_pos = '0;
      end
    endcase
    return r;
  endfunction

  task automatic report_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    kmp_result_t want_r;
    if (!rst_n) begin
      pat_len = 0;
      match_len = 0;
      text_pos = '0;
      error_count = 0;
      expected_q.delete();
      for (int i = 0; i < MAX_LEN; i++) begin
        pat_bytes[i] = '0;
        borders[i] = 0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t result with no request waiting: expected none actual status %0d border %0d",
                   $time, out_status, out_border_length);
        end else begin
          want_r = expected_q.pop_front();
          report_field("status", 64'(want_r.status), 64'(out_status));
          report_field("border_length", 64'(want_r.border), 64'(out_border_length));
          report_field("match_found", 64'(want_r.found), 64'(out_match_found));
          report_field("match_start", 64'(want_r.start), 64'(out_match_start));
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.insert(expected_q.size(), predict_result(in_operation, in_byte_value));
      end
    end
    pending_count <= expected_q.size();
  end

endmodule

// ----- dv/kmp_pattern_matcher_test.sv -----
// kmp matcher testbench top: clock, reset, request stimulus with idling, result backpressure, and the verdict
module kmp_pattern_matcher_test
  import kmp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W = $clog2(MAX_PATTERN_DEF + 1);
  localparam int unsigned ITEM_TARGET = 1000;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_operation = OP_CLEAR;
  logic [7:0]                   in_byte_value = 8'h00;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_status;
  logic [LEN_W-1:0]             out_border_length;
  logic                         out_match_found;
  logic [POSITION_BITS_DEF-1:0] out_match_start;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_level = 0;
  int unsigned stall_level = 0;
  int unsigned stall_left = 0;

  kmp_pattern_matcher dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_byte_value(in_byte_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_border_length(out_border_length),
    .out_match_found(out_match_found),
    .out_match_start(out_match_start)
  );

  kmp_match_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_byte_value(in_byte_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_border_length(out_border_length),
    .out_match_found(out_match_found),
    .out_match_start(out_match_start),
    .error_count(error_count),
    .pending_count(pending_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result-side backpressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_level != 0 && $urandom_range(0, 15) < stall_level) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic issue_request(input logic [1:0] op, input logic [7:0] b);
    if (gap_level != 0 && $urandom_range(0, 7) < gap_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    logic [7:0]  alphabet [4];
    logic [7:0]  pattern_q [$];
    logic [7:0]  b;
    int unsigned span;
    int unsigned plen;
    int unsigned period;
    int unsigned text_len;
    int unsigned n;
    int unsigned cut;
    logic        late;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    gap_level = 1;
    stall_level = 2;
    // empty-pattern scan, then restart with a byte that must be ignored
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_RESTART, 8'hA5);
    issue_request(OP_APPEND, 8'h00);
    issue_request(OP_APPEND, 8'hFF);
    issue_request(OP_APPEND, 8'h00);
    // overlapping hits on 00 ff 00
    issue_request(OP_SCAN, 8'h00);
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_SCAN, 8'h00);
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_SCAN, 8'h00);
    // append in the middle of a scan keeps the matched length
    issue_request(OP_APPEND, 8'hFF);
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_SCAN, 8'h00);
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_RESTART, 8'h00);
    issue_request(OP_SCAN, 8'h00);
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_SCAN, 8'h00);
    issue_request(OP_SCAN, 8'hFF);
    issue_request(OP_CLEAR, 8'h5A);
    issue_request(OP_SCAN, 8'h00);

    // full-length periodic pattern: store overflow and long failure-chain walks
    gap_level = $urandom_range(0, 2);
    stall_level = $urandom_range(0, 2);
    issue_request(OP_CLEAR, 8'($urandom_range(0, 255)));
    foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
    period = $urandom_range(1, 5);
    for (int i = 0; i < MAX_PATTERN_DEF + 2; i++) begin
      issue_request(OP_APPEND, alphabet[(i % period) % 4]);
    end
    for (int i = 0; i < 320; i++) begin
      b = alphabet[(i % period) % 4];
      if (i < 24 && $urandom_range(0, 5) == 0) b = 8'($urandom_range(0, 255));
      issue_request(OP_SCAN, b);
    end

    while (sent_count < ITEM_TARGET) begin
      late = (sent_count + 150 >= ITEM_TARGET);
      gap_level = late ? 0 : $urandom_range(0, 3);
      stall_level = late ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
        repeat (15) begin
          issue_request(2'($urandom_range(OP_CLEAR, OP_RESTART)), 8'($urandom_range(0, 255)));
        end
      end else begin
        // mostly a fresh pattern; sometimes keep the old one and extend it
        case ($urandom_range(0, 5)) inside
          [0:3]: issue_request(OP_CLEAR, 8'($urandom_range(0, 255)));
          4: issue_request(OP_RESTART, 8'($urandom_range(0, 255)));
          default: ;
        endcase
        foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
        span = $urandom_range(1, 4);
        plen = $urandom_range(1, 10);
        pattern_q.delete();
        repeat (plen) begin
          b = alphabet[$urandom_range(0, span - 1)];
          pattern_q.insert(pattern_q.size(), b);
          issue_request(OP_APPEND, b);
        end
        text_len = $urandom_range(8, 40);
        n = 0;
        while (n < text_len) begin
          case ($urandom_range(0, 6)) inside
            [0:2]: begin
              foreach (pattern_q[j]) issue_request(OP_SCAN, pattern_q[j]);
              n += pattern_q.size();
            end
            3: begin
              cut = $urandom_range(1, pattern_q.size());
              for (int j = 0; j < cut; j++) issue_request(OP_SCAN, pattern_q[j]);
              n += cut;
            end
            [4:5]: begin
              issue_request(OP_SCAN, alphabet[$urandom_range(0, span - 1)]);
              n++;
            end
            default: begin
              if ($urandom_range(0, 3) == 0) begin
                issue_request(OP_RESTART, 8'($urandom_range(0, 255)));
              end else begin
                issue_request(OP_SCAN, 8'($urandom_range(0, 255)));
              end
              n++;
            end
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
